[hw/rtl/assert_macros.svh]
// assertion helpers, sampled on the rising edge of clk and disabled in reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[hw/rtl/lfa_pkg.sv]
package lfa_pkg;

  localparam int OpW    = 3;
  localparam int IdW    = 6;
  localparam int ErrW   = 2;
  localparam int CountW = 7;

  typedef enum logic [OpW-1:0] {
    OP_ALLOC     = 3'd0,
    OP_TAKE      = 3'd1,
    OP_FREE      = 3'd2,
    OP_NOTIFY    = 3'd3,
    OP_DRAIN     = 3'd4,
    OP_CLEAR_LOG = 3'd5,
    OP_CLEAR_ALL = 3'd6
  } op_t;

  typedef enum logic [ErrW-1:0] {
    ERR_OK       = 2'd0,
    ERR_NO_FREE  = 2'd1,
    ERR_UNUSED   = 2'd2,
    ERR_IN_USE   = 2'd3
  } err_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_EMIT
  } state_t;

endpackage

[hw/rtl/lfa_cmd_if.sv]
interface lfa_cmd_if #(
  parameter int HANDLE_BITS = 32
);
  logic                        valid;
  logic                        ready;
  logic [lfa_pkg::OpW-1:0]     opcode;
  logic [lfa_pkg::IdW-1:0]     slot_id;
  logic [HANDLE_BITS-1:0]      handle;

  modport source (output valid, opcode, slot_id, handle, input ready);
  modport sink   (input valid, opcode, slot_id, handle, output ready);
endinterface

[hw/rtl/lfa_res_if.sv]
interface lfa_res_if #(
  parameter int HANDLE_BITS = 32
);
  logic                         valid;
  logic                         ready;
  logic [lfa_pkg::IdW-1:0]      out_id;
  logic [HANDLE_BITS-1:0]       out_handle;
  logic                         removed;
  logic                         log_empty;
  logic [lfa_pkg::ErrW-1:0]     error_code;
  logic [lfa_pkg::CountW-1:0]   assigned_count;
  logic                         last;

  modport source (output valid, out_id, out_handle, removed, log_empty, error_code,
                  assigned_count, last, input ready);
  modport sink   (input valid, out_id, out_handle, removed, log_empty, error_code,
                  assigned_count, last, output ready);
endinterface

[hw/rtl/lowest_free_id_allocator_unit.sv]
// Lowest-free ID allocator with a change log. Each command word on cmd gives
// one result word on res, except drain, which gives one word per logged ID in
// ascending order (last set on the final one) or a single word with log_empty
// set when nothing is logged. Allocate, take, free, notify and both clears
// pass through accept, which reads the bound-handle memory, and then execute,
// which updates the in-use map, the log and the count. A drain scans the IDs
// upward from zero to the highest logged one and, for each logged entry,
// reads the log memory before it emits that entry's word. The block takes a
// new command while the previous result still waits on res; it holds in
// execute only if the output register is still full. Handle memories need no
// clearing after reset: the block is ready as soon as rst drops.
module lowest_free_id_allocator_unit #(
  parameter int NUM_IDS     = 64,
  parameter int HANDLE_BITS = 32
) (
  input  logic       clk,
  input  logic       rst,
  lfa_cmd_if.sink    cmd,
  lfa_res_if.source  res
);

  localparam int IdxW = (NUM_IDS > 1) ? $clog2(NUM_IDS) : 1;
  localparam logic [lfa_pkg::IdW:0] NumIdsW = (lfa_pkg::IdW + 1)'(NUM_IDS);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_IDS - 1);

  lfa_pkg::state_t state, state_next;

  // latched command
  lfa_pkg::op_t              op_q;
  logic [lfa_pkg::IdW-1:0]   slot_q;
  logic [HANDLE_BITS-1:0]    hdl_q;

  logic [NUM_IDS-1:0]        in_use_map, in_use_map_next;
  logic [NUM_IDS-1:0]        log_pending, log_pending_next;
  logic [lfa_pkg::CountW-1:0] in_use_total, in_use_total_next;
  logic [IdxW-1:0]           scan_idx, scan_idx_next;

  logic [IdxW-1:0]           free_id, free_id_c;
  logic                      all_full;

  // bound handle memory
  logic [HANDLE_BITS-1:0]    bound_mem [NUM_IDS];
  logic [HANDLE_BITS-1:0]    bound_rd;
  logic                      bnd_we;
  logic [IdxW-1:0]           bnd_wa;
  logic [HANDLE_BITS-1:0]    bnd_wd;
  logic                      bnd_re;

  // log memory: removed flag on top of the handle
  logic [HANDLE_BITS:0]      log_mem [NUM_IDS];
  logic [HANDLE_BITS:0]      log_rd;
  logic                      log_we;
  logic [IdxW-1:0]           log_wa;
  logic [HANDLE_BITS:0]      log_wd;
  logic                      log_re;

  // output register
  logic                       out_valid, out_ld;
  logic [lfa_pkg::IdW-1:0]    o_id, o_id_next;
  logic [HANDLE_BITS-1:0]     o_handle, o_handle_next;
  logic                       o_removed, o_removed_next;
  logic                       o_empty, o_empty_next;
  lfa_pkg::err_t              o_err, o_err_next;
  logic [lfa_pkg::CountW-1:0] o_count, o_count_next;
  logic                       o_last, o_last_next;

  logic                       out_ok;
  logic                       id_ok;
  logic [IdxW-1:0]            slot_ix;
  logic                       more_after;
  logic                       accept;

  assign accept     = cmd.valid && cmd.ready;
  assign cmd.ready  = (state == lfa_pkg::ST_IDLE) && !rst;
  assign out_ok     = !out_valid || res.ready;
  assign id_ok      = {1'b0, slot_q} < NumIdsW;
  assign slot_ix    = slot_q[IdxW-1:0];
  assign more_after = |((log_pending >> scan_idx) >> 1);
  assign bnd_re     = accept && ({1'b0, cmd.slot_id} < NumIdsW);

  assign res.valid          = out_valid;
  assign res.out_id         = o_id;
  assign res.out_handle     = o_handle;
  assign res.removed        = o_removed;
  assign res.log_empty      = o_empty;
  assign res.error_code     = o_err;
  assign res.assigned_count = o_count;
  assign res.last           = o_last;

  // lowest clear bit of the map, registered every cycle
  always_comb begin
    free_id_c = '0;
    for (int i = NUM_IDS - 1; i >= 0; i--) begin
      if (!in_use_map[i]) free_id_c = IdxW'(i);
    end
  end

  always_ff @(posedge clk) begin
    free_id  <= free_id_c;
    all_full <= &in_use_map;
  end

  always_ff @(posedge clk) begin
    if (bnd_we) bound_mem[bnd_wa] <= bnd_wd;
    if (bnd_re) bound_rd <= bound_mem[cmd.slot_id[IdxW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (log_we) log_mem[log_wa] <= log_wd;
    if (log_re) log_rd <= log_mem[scan_idx];
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q   <= lfa_pkg::op_t'(cmd.opcode);
      slot_q <= cmd.slot_id;
      hdl_q  <= cmd.handle;
    end
    if (out_ld) begin
      o_id      <= o_id_next;
      o_handle  <= o_handle_next;
      o_removed <= o_removed_next;
      o_empty   <= o_empty_next;
      o_err     <= o_err_next;
      o_count   <= o_count_next;
      o_last    <= o_last_next;
    end
    scan_idx <= scan_idx_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= lfa_pkg::ST_IDLE;
      in_use_map   <= '0;
      log_pending  <= '0;
      in_use_total <= '0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      in_use_map   <= in_use_map_next;
      log_pending  <= log_pending_next;
      in_use_total <= in_use_total_next;
      out_valid    <= out_ld || (out_valid && !res.ready);
    end
  end

  always_comb begin
    state_next        = state;
    in_use_map_next   = in_use_map;
    log_pending_next  = log_pending;
    in_use_total_next = in_use_total;
    scan_idx_next     = scan_idx;
    bnd_we            = 1'b0;
    bnd_wa            = slot_ix;
    bnd_wd            = hdl_q;
    log_we            = 1'b0;
    log_wa            = slot_ix;
    log_wd            = {1'b0, hdl_q};
    log_re            = 1'b0;
    out_ld            = 1'b0;
    o_id_next         = '0;
    o_handle_next     = '0;
    o_removed_next    = 1'b0;
    o_empty_next      = 1'b0;
    o_err_next        = lfa_pkg::ERR_OK;
    o_count_next      = in_use_total;
    o_last_next       = 1'b1;

    unique case (state)
      lfa_pkg::ST_IDLE: begin
        if (accept) state_next = lfa_pkg::ST_EXEC;
      end

      lfa_pkg::ST_EXEC: begin
        if (out_ok) begin
          out_ld     = 1'b1;
          state_next = lfa_pkg::ST_IDLE;
          case (op_q)
            lfa_pkg::OP_ALLOC: begin
              if (all_full) begin
                o_err_next = lfa_pkg::ERR_NO_FREE;
              end else begin
                in_use_map_next[free_id]  = 1'b1;
                log_pending_next[free_id] = 1'b1;
                bnd_we            = 1'b1;
                bnd_wa            = free_id;
                log_we            = 1'b1;
                log_wa            = free_id;
                in_use_total_next = in_use_total + 1'b1;
                o_id_next         = lfa_pkg::IdW'(free_id);
              end
            end
            lfa_pkg::OP_TAKE: begin
              if (!id_ok) begin
                o_err_next = lfa_pkg::ERR_NO_FREE;
              end else if (in_use_map[slot_ix]) begin
                o_err_next = lfa_pkg::ERR_IN_USE;
              end else begin
                in_use_map_next[slot_ix] = 1'b1;
                bnd_we            = 1'b1;
                in_use_total_next = in_use_total + 1'b1;
              end
            end
            lfa_pkg::OP_FREE: begin
              if (!id_ok || !in_use_map[slot_ix]) begin
                o_err_next = lfa_pkg::ERR_UNUSED;
              end else begin
                in_use_map_next[slot_ix]  = 1'b0;
                log_pending_next[slot_ix] = 1'b1;
                log_we            = 1'b1;
                log_wd            = {1'b1, {HANDLE_BITS{1'b0}}};
                in_use_total_next = in_use_total - 1'b1;
              end
            end
            lfa_pkg::OP_NOTIFY: begin
              if (!id_ok || !in_use_map[slot_ix]) begin
                o_err_next = lfa_pkg::ERR_UNUSED;
              end else begin
                log_pending_next[slot_ix] = 1'b1;
                log_we = 1'b1;
                log_wd = {1'b0, bound_rd};
              end
            end
            lfa_pkg::OP_DRAIN: begin
              if (log_pending == '0) begin
                o_empty_next = 1'b1;
              end else begin
                out_ld        = 1'b0;
                scan_idx_next = '0;
                state_next    = lfa_pkg::ST_SCAN;
              end
            end
            lfa_pkg::OP_CLEAR_LOG: begin
              log_pending_next = '0;
            end
            lfa_pkg::OP_CLEAR_ALL: begin
              in_use_map_next   = '0;
              log_pending_next  = '0;
              in_use_total_next = '0;
            end
            default: begin
            end
          endcase
          o_count_next = in_use_total_next;
        end
      end

      lfa_pkg::ST_SCAN: begin
        if (log_pending[scan_idx]) begin
          log_re     = 1'b1;
          state_next = lfa_pkg::ST_EMIT;
        end else if (scan_idx != LastIdx) begin
          scan_idx_next = scan_idx + 1'b1;
        end else begin
          state_next = lfa_pkg::ST_IDLE;
        end
      end

      lfa_pkg::ST_EMIT: begin
        if (out_ok) begin
          out_ld                     = 1'b1;
          o_id_next                  = lfa_pkg::IdW'(scan_idx);
          o_removed_next             = log_rd[HANDLE_BITS];
          o_handle_next              = log_rd[HANDLE_BITS] ? '0 : log_rd[HANDLE_BITS-1:0];
          o_last_next                = !more_after;
          log_pending_next[scan_idx] = 1'b0;
          if (more_after) begin
            scan_idx_next = scan_idx + 1'b1;
            state_next    = lfa_pkg::ST_SCAN;
          end else begin
            state_next = lfa_pkg::ST_IDLE;
          end
        end
      end

      default: state_next = lfa_pkg::ST_IDLE;
    endcase
  end

`include "assert_macros.svh"

  `ASSERT_IMPLIES(a_count_matches_map, 1'b1, in_use_total == $countones(in_use_map))
  `ASSERT_IMPLIES(a_emit_is_pending, state == lfa_pkg::ST_EMIT, log_pending[scan_idx])
  `ASSERT_IMPLIES(a_scan_has_work, state == lfa_pkg::ST_SCAN, log_pending != '0)
  `ASSERT_IMPLIES(a_free_id_is_free, state == lfa_pkg::ST_EXEC && !all_full,
                  !in_use_map[free_id])
  `ASSERT_NEXT(a_emit_loads_output, state == lfa_pkg::ST_EMIT && out_ok, out_valid)

endmodule
